// File: src/rational_arith_unit_assert.svh
// Assertion macros for the rational arithmetic unit.
// Included by the modules that carry checks; no other dependencies.
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH
`ifndef SYNTH
`define RAU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RAU_ASSERT(lbl, clk, rst, prop, msg)
`define RAU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: src/rau_pkg.sv
// Shared types and constants of the rational arithmetic unit.
// No dependencies.
package rau_pkg;
   localparam int OPERAND_BITS_DEF = 16;
   localparam int RES_BITS = 33;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_MUL1,
      DP_MUL2,
      DP_MUL3,
      DP_MUL4,
      DP_GCD_DIV,
      DP_GCD_STEP,
      DP_DIV_NUM,
      DP_NUM_STORE,
      DP_DEN_STORE,
      DP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_ctrl_type;

   typedef struct packed {
      logic y_zero;
      logic x_zero;
      logic div_done;
      logic out_free;
   } dp_status_type;
endpackage

// File: src/rau_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rational_arith_unit_assert.svh.
`include "rational_arith_unit_assert.svh"
module rau_div #(
   parameter int WIDTH = 33
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [WIDTH-1:0] dividend,
   input  logic signed [WIDTH-1:0] divisor,
   output logic                    done,
   output logic signed [WIDTH-1:0] quot,
   output logic signed [WIDTH-1:0] rem
);
   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] q_ff, q_in, r_ff, r_in, dv_ff, dv_in;
   logic             neg_q_ff, neg_q_in, neg_r_ff, neg_r_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [WIDTH:0]   r_shift, diff;

   always_comb begin
      r_shift = {r_ff, q_ff[WIDTH-1]};
      diff = r_shift - {1'b0, dv_ff};
      q_in = q_ff;
      r_in = r_ff;
      dv_in = dv_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in = dividend[WIDTH-1] ? -dividend : dividend;
         dv_in = divisor[WIDTH-1] ? -divisor : divisor;
         r_in = '0;
         neg_q_in = dividend[WIDTH-1] ^ divisor[WIDTH-1];
         neg_r_in = dividend[WIDTH-1];
         cnt_in = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[WIDTH]) begin
            r_in = diff[WIDTH-1:0];
         end else begin
            r_in = r_shift[WIDTH-1:0];
         end
         q_in = {q_ff[WIDTH-2:0], ~diff[WIDTH]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      dv_ff <= dv_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   assign done = done_ff;
   assign quot = neg_q_ff ? -$signed(q_ff) : $signed(q_ff);
   assign rem = neg_r_ff ? -$signed(r_ff) : $signed(r_ff);

   `RAU_ASSERT(a_div_nonzero, clock, reset, start |-> (divisor != '0), "divide by zero")
   `RAU_ASSERT(a_done_pulse, clock, reset, done_ff |=> !done_ff, "done longer than a cycle")
endmodule

// File: src/rau_datapath.sv
// Operand registers, shared multiplier, Euclid registers and output register.
// Depends on rau_pkg, rau_div and rational_arith_unit_assert.svh.
`include "rational_arith_unit_assert.svh"
module rau_datapath #(
   parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rau_pkg::dp_ctrl_type           ctrl,
   output rau_pkg::dp_status_type         status,
   input  logic [1:0]                     req_command,
   input  logic signed [OPERAND_BITS-1:0] req_a_num,
   input  logic signed [OPERAND_BITS-1:0] req_a_den,
   input  logic signed [OPERAND_BITS-1:0] req_b_num,
   input  logic signed [OPERAND_BITS-1:0] req_b_den,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [rau_pkg::RES_BITS-1:0] rsp_res_num,
   output logic signed [rau_pkg::RES_BITS-1:0] rsp_res_den,
   output logic                           rsp_zero_den
);
   localparam int W = OPERAND_BITS;
   localparam int IW = 2 * W + 1;
   localparam int RB = rau_pkg::RES_BITS;

   rau_pkg::cmd_type      cmd_ff;
   logic signed [W-1:0]   an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [W-1:0]   mul_a, mul_b;
   logic signed [2*W-1:0] mul_p, prod_ff;
   logic signed [IW-1:0]  n_ff, d_ff, x_ff, y_ff;
   logic signed [IW-1:0]  div_dividend, div_divisor, quot, rem;
   logic                  div_start, div_done;
   logic                  out_valid_ff;
   logic signed [RB-1:0]  out_num_ff, out_den_ff;
   logic                  out_zero_ff;

   always_comb begin
      mul_a = an_ff;
      mul_b = bd_ff;
      unique case (ctrl.op)
         rau_pkg::DP_MUL1: begin
            mul_a = an_ff;
            mul_b = (cmd_ff == rau_pkg::CMD_MUL) ? bn_ff : bd_ff;
         end
         rau_pkg::DP_MUL2: begin
            mul_a = bn_ff;
            mul_b = ad_ff;
         end
         rau_pkg::DP_MUL3: begin
            mul_a = ad_ff;
            mul_b = (cmd_ff == rau_pkg::CMD_DIV) ? bn_ff : bd_ff;
         end
         default: begin
            mul_a = an_ff;
            mul_b = bd_ff;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   assign div_start = (ctrl.op == rau_pkg::DP_GCD_DIV) || (ctrl.op == rau_pkg::DP_DIV_NUM)
                      || (ctrl.op == rau_pkg::DP_NUM_STORE);
   always_comb begin
      div_dividend = d_ff;
      div_divisor = x_ff;
      if (ctrl.op == rau_pkg::DP_GCD_DIV) begin
         div_dividend = x_ff;
         div_divisor = y_ff;
      end else if (ctrl.op == rau_pkg::DP_DIV_NUM) begin
         div_dividend = n_ff;
      end
   end

   rau_div #(.WIDTH(IW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (quot),
      .rem      (rem)
   );

   always_ff @(posedge clock) begin
      unique case (ctrl.op)
         rau_pkg::DP_LOAD: begin
            cmd_ff <= rau_pkg::cmd_type'(req_command);
            an_ff <= req_a_num;
            ad_ff <= req_a_den;
            bn_ff <= req_b_num;
            bd_ff <= req_b_den;
         end
         rau_pkg::DP_MUL1: prod_ff <= mul_p;
         rau_pkg::DP_MUL2: begin
            n_ff <= IW'(prod_ff);
            prod_ff <= mul_p;
         end
         rau_pkg::DP_MUL3: begin
            if (cmd_ff == rau_pkg::CMD_ADD) begin
               n_ff <= n_ff + IW'(prod_ff);
            end else if (cmd_ff == rau_pkg::CMD_SUB) begin
               n_ff <= n_ff - IW'(prod_ff);
            end
            prod_ff <= mul_p;
         end
         rau_pkg::DP_MUL4: begin
            d_ff <= IW'(prod_ff);
            x_ff <= n_ff;
            y_ff <= IW'(prod_ff);
         end
         rau_pkg::DP_GCD_STEP: begin
            x_ff <= y_ff;
            y_ff <= rem;
         end
         rau_pkg::DP_NUM_STORE: n_ff <= quot;
         rau_pkg::DP_DEN_STORE: d_ff <= quot;
         default: begin
         end
      endcase
   end

   // output register: frees the core while the result waits
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctrl.op == rau_pkg::DP_OUT) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (ctrl.op == rau_pkg::DP_OUT) begin
         out_num_ff <= RB'(n_ff);
         out_den_ff <= RB'(d_ff);
         out_zero_ff <= (d_ff == '0);
      end
   end

   assign status.y_zero = (y_ff == '0);
   assign status.x_zero = (x_ff == '0);
   assign status.div_done = div_done;
   assign status.out_free = !out_valid_ff || !rsp_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_res_num = out_num_ff;
   assign rsp_res_den = out_den_ff;
   assign rsp_zero_den = out_zero_ff;

   `RAU_ASSERT(a_out_no_overwrite, clock, reset,
      (ctrl.op == rau_pkg::DP_OUT) |-> !(out_valid_ff && rsp_stall), "result overwritten")
endmodule

// File: src/rau_ctrl.sv
// Sequencer: multiply steps, Euclid loop, reduction divides, result hand-off.
// Depends on rau_pkg and rational_arith_unit_assert.svh.
`include "rational_arith_unit_assert.svh"
module rau_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rau_pkg::dp_status_type status,
   output rau_pkg::dp_ctrl_type   ctrl
);
   typedef enum logic [3:0] {
      S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_GCD_TEST, S_GCD_WAIT,
      S_NUM_WAIT, S_DEN_WAIT, S_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctrl.op = rau_pkg::DP_NOP;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.op = rau_pkg::DP_LOAD;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            ctrl.op = rau_pkg::DP_MUL1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            ctrl.op = rau_pkg::DP_MUL2;
            state_in = S_MUL3;
         end
         S_MUL3: begin
            ctrl.op = rau_pkg::DP_MUL3;
            state_in = S_MUL4;
         end
         S_MUL4: begin
            ctrl.op = rau_pkg::DP_MUL4;
            state_in = S_GCD_TEST;
         end
         S_GCD_TEST: begin
            priority if (!status.y_zero) begin
               ctrl.op = rau_pkg::DP_GCD_DIV;
               state_in = S_GCD_WAIT;
            end else if (status.x_zero) begin
               // both zero: 0/0 passes unreduced
               state_in = S_OUT;
            end else begin
               ctrl.op = rau_pkg::DP_DIV_NUM;
               state_in = S_NUM_WAIT;
            end
         end
         S_GCD_WAIT: begin
            if (status.div_done) begin
               ctrl.op = rau_pkg::DP_GCD_STEP;
               state_in = S_GCD_TEST;
            end
         end
         S_NUM_WAIT: begin
            if (status.div_done) begin
               ctrl.op = rau_pkg::DP_NUM_STORE;
               state_in = S_DEN_WAIT;
            end
         end
         S_DEN_WAIT: begin
            if (status.div_done) begin
               ctrl.op = rau_pkg::DP_DEN_STORE;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               ctrl.op = rau_pkg::DP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   `RAU_ASSERT(a_done_in_wait, clock, reset,
      status.div_done |-> (state_ff == S_GCD_WAIT || state_ff == S_NUM_WAIT
                           || state_ff == S_DEN_WAIT), "divider done outside wait")
   `RAU_ASSERT(a_gcd_loop, clock, reset,
      (state_ff == S_GCD_TEST && !status.y_zero) |=> (state_ff == S_GCD_WAIT),
      "Euclid step skipped")
endmodule

// File: src/rational_arith_unit.sv
// Rational arithmetic unit top level: sequencer plus datapath.
// Depends on rau_pkg, rau_ctrl and rau_datapath.
//
// Usage:
//   Request channel (req_valid/req_stall) carries a command (add, subtract,
//   multiply, divide) and two signed fractions a_num/a_den, b_num/b_den.
//   Response channel (rsp_valid/rsp_stall) returns res_num/res_den reduced
//   by their gcd, plus zero_den when the denominator is zero (0/0 when both
//   cross products are zero, left unreduced).
//   One item is worked at a time; req_stall is high from the transfer until
//   the result enters the output register.
//   Each divide runs one quotient bit per cycle through the single shared
//   divider, which sets the rate; no divide runs when both cross products are
//   zero. Multiplies share one multiplier in turn.
//   While a result waits under rsp_stall the next request is still taken and
//   worked; it waits in the core until the output register frees.
//   Reset is synchronous, active high, and returns the block to idle with no
//   result pending.
module rational_arith_unit #(
   parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_command,
   input  logic signed [OPERAND_BITS-1:0] req_a_num,
   input  logic signed [OPERAND_BITS-1:0] req_a_den,
   input  logic signed [OPERAND_BITS-1:0] req_b_num,
   input  logic signed [OPERAND_BITS-1:0] req_b_den,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [rau_pkg::RES_BITS-1:0] rsp_res_num,
   output logic signed [rau_pkg::RES_BITS-1:0] rsp_res_den,
   output logic                           rsp_zero_den
);
   rau_pkg::dp_ctrl_type   ctrl;
   rau_pkg::dp_status_type status;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   rau_datapath #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .status       (status),
      .req_command  (req_command),
      .req_a_num    (req_a_num),
      .req_a_den    (req_a_den),
      .req_b_num    (req_b_num),
      .req_b_den    (req_b_den),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_res_num  (rsp_res_num),
      .rsp_res_den  (rsp_res_den),
      .rsp_zero_den (rsp_zero_den)
   );
endmodule

// File: sim/rau_checker.sv
`timescale 1ns / 1ps
// Checker for the rational arithmetic unit: watches both channels, predicts
// the reduced fraction per request transfer and compares. Depends on rau_pkg.
module rau_checker #(
   parameter int OPERAND_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [1:0]                     req_command,
   input  logic signed [OPERAND_BITS-1:0] req_a_num,
   input  logic signed [OPERAND_BITS-1:0] req_a_den,
   input  logic signed [OPERAND_BITS-1:0] req_b_num,
   input  logic signed [OPERAND_BITS-1:0] req_b_den,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic signed [rau_pkg::RES_BITS-1:0] rsp_res_num,
   input  logic signed [rau_pkg::RES_BITS-1:0] rsp_res_den,
   input  logic                           rsp_zero_den,
   output int                             fail_count,
   output int                             pending
);
   localparam int RB = rau_pkg::RES_BITS;

   typedef struct packed {
      logic [RB-1:0] num;
      logic [RB-1:0] den;
      logic          zden;
   } fraction_type;

   fraction_type reduced_q[$];

   function automatic fraction_type reduce_fraction(rau_pkg::cmd_type cmd, longint an,
                                                    longint ad, longint bn, longint bd);
      longint n, d, x, y, t;
      fraction_type r;
      case (cmd)
         rau_pkg::CMD_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
         rau_pkg::CMD_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
         rau_pkg::CMD_MUL: begin n = an * bn; d = ad * bd; end
         default: begin n = an * bd; d = ad * bn; end
      endcase
      x = n;
      y = d;
      while (y != 0) begin
         t = y;
         y = x % y;   // truncating remainder, signs follow the dividend
         x = t;
      end
      if (x != 0) begin
         n = n / x;
         d = d / x;
      end
      r.num = n[RB-1:0];
      r.den = d[RB-1:0];
      r.zden = (d == 0);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [RB-1:0] got,
                                  logic [RB-1:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      fraction_type e;
      if (!reset) begin
         if (req_valid && !req_stall)
            reduced_q.push_back(reduce_fraction(rau_pkg::cmd_type'(req_command),
               longint'(req_a_num), longint'(req_a_den),
               longint'(req_b_num), longint'(req_b_den)));
         if (rsp_valid && !rsp_stall) begin
            if (reduced_q.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_res_num, '0);
            end else begin
               e = reduced_q.pop_front();
               if (rsp_res_num !== e.num) report_mismatch("res_num", rsp_res_num, e.num);
               if (rsp_res_den !== e.den) report_mismatch("res_den", rsp_res_den, e.den);
               if (rsp_zero_den !== e.zden)
                  report_mismatch("zero_den", RB'(rsp_zero_den), RB'(e.zden));
            end
         end
         pending = reduced_q.size();
      end
   end
endmodule

// File: sim/tb_rational_arith_unit.sv
`timescale 1ns / 1ps
// Top of the rational arithmetic unit testbench: clock, reset, stimulus and
// verdict. Depends on rau_pkg, rational_arith_unit and rau_checker.
module tb_rational_arith_unit;
   localparam int OB = 16;
   localparam int RANDOM_ITEMS = 1380;
   localparam int CYCLE_LIMIT = 10000000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_command = rau_pkg::CMD_ADD;
   logic signed [OB-1:0] req_a_num = '0, req_a_den = '0, req_b_num = '0, req_b_den = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [rau_pkg::RES_BITS-1:0] rsp_res_num, rsp_res_den;
   logic rsp_zero_den;
   int fail_count, pending;
   int cycles = 0;
   bit quiet = 0;       // no idling in the final stretch

   always #2 clock = ~clock;

   rational_arith_unit #(.OPERAND_BITS(OB)) DUT (.*);

   rau_checker #(.OPERAND_BITS(OB)) u_checker (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_rational_arith_unit: errors");
         $finish;
      end
   end

   task automatic send(rau_pkg::cmd_type c, int an, int ad, int bn, int bd);
      int gap;
      if (!quiet && $urandom_range(3) == 0) begin
         req_valid <= 0;
         gap = $urandom_range(13, 1);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_command <= c;
      req_a_num <= OB'(an);
      req_a_den <= OB'(ad);
      req_b_num <= OB'(bn);
      req_b_den <= OB'(bd);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic int rand_operand();
      case ($urandom_range(5))
         0: return int'($urandom_range(8));
         1: return -int'($urandom_range(8));
         2: return int'($urandom_range(255));
         3: return ($urandom_range(1) == 0) ? (1 << (OB - 1)) - 1 : -(1 << (OB - 1));
         default: return int'($urandom);
      endcase
   endfunction

   // receiver: random stall bursts, one long hold-off early on
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      repeat (20) @(negedge clock);
      rsp_stall <= 1;
      repeat (3000) @(negedge clock);
      rsp_stall <= 0;
      forever begin
         if (!quiet && $urandom_range(2) == 0) begin
            rsp_stall <= 1;
            n = $urandom_range(13, 1);
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 0;
         n = $urandom_range(20, 1);
         repeat (n) @(negedge clock);
      end
   end

   initial begin
      int mx, mn;
      mx = (1 << (OB - 1)) - 1;
      mn = -(1 << (OB - 1));
      repeat (4) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: each command, extremes, both-zero and zero denominators
      send(rau_pkg::CMD_ADD, 1, 2, 1, 3);
      send(rau_pkg::CMD_SUB, 1, 2, 1, 2);
      send(rau_pkg::CMD_MUL, -3, 4, 2, -9);
      send(rau_pkg::CMD_DIV, 3, 4, 0, 5);
      send(rau_pkg::CMD_ADD, 0, 0, 0, 0);
      send(rau_pkg::CMD_MUL, 5, 0, 7, 3);
      send(rau_pkg::CMD_DIV, -5, 3, 0, 2);
      send(rau_pkg::CMD_ADD, mx, mx, mx, mx);
      send(rau_pkg::CMD_SUB, mn, mn, mx, mn);
      send(rau_pkg::CMD_MUL, mn, mn, mn, mn);
      send(rau_pkg::CMD_DIV, mn, mx, mn, mx);
      send(rau_pkg::CMD_ADD, mn, -1, mn, -1);
      send(rau_pkg::CMD_SUB, -1, -1, -1, -1);
      send(rau_pkg::CMD_MUL, -1, mx, 0, mn);
      send(rau_pkg::CMD_DIV, 6, -4, -9, 15);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - 150) quiet = 1;
         send(rau_pkg::cmd_type'(2'($urandom_range(3))), rand_operand(), rand_operand(),
              rand_operand(), rand_operand());
      end
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (fail_count == 0)
         $display("tb_rational_arith_unit: clean");
      else
         $display("tb_rational_arith_unit: errors");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+src
src/rau_pkg.sv
src/rau_div.sv
src/rau_datapath.sv
src/rau_ctrl.sv
src/rational_arith_unit.sv
sim/rau_checker.sv
sim/tb_rational_arith_unit.sv
